FILE: hdl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared constants, types and the twiddle table for the radix-2 DIF FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int unsigned PointsDef    = 64;
  localparam int unsigned Log2PointsDef = 6;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned DataW        = 23;
  localparam int unsigned CoefW        = 17;
  localparam int unsigned TwIdxW       = 6;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [CoefW-1:0] coef_t;

  // Q1.15 cosine, quarter wave, angle m/64 of a turn
  function automatic coef_t quarter_cos(input logic [4:0] m);
    coef_t c;
    c = '0;
    case (m)
      5'd0:  c = 17'sd32767;
      5'd1:  c = 17'sd32609;
      5'd2:  c = 17'sd32137;
      5'd3:  c = 17'sd31356;
      5'd4:  c = 17'sd30273;
      5'd5:  c = 17'sd28898;
      5'd6:  c = 17'sd27245;
      5'd7:  c = 17'sd25329;
      5'd8:  c = 17'sd23170;
      5'd9:  c = 17'sd20787;
      5'd10: c = 17'sd18204;
      5'd11: c = 17'sd15446;
      5'd12: c = 17'sd12539;
      5'd13: c = 17'sd9512;
      5'd14: c = 17'sd6393;
      5'd15: c = 17'sd3212;
      default: c = '0;
    endcase
    return c;
  endfunction

  // full-turn cosine over 64 angle steps
  function automatic coef_t cos64(input logic [TwIdxW-1:0] m);
    coef_t c;
    logic [6:0] mm;
    c  = '0;
    mm = {1'b0, m};
    if (mm <= 7'd16)      c = quarter_cos(5'(mm));
    else if (mm <= 7'd32) c = -quarter_cos(5'(7'd32 - mm));
    else if (mm <= 7'd48) c = -quarter_cos(5'(mm - 7'd32));
    else                  c = quarter_cos(5'(7'd64 - mm));
    return c;
  endfunction

  function automatic coef_t sin64(input logic [TwIdxW-1:0] m);
    return cos64(m - TwIdxW'(16));
  endfunction

endpackage

FILE: hdl/radix2_dif_complex_fft.sv
// ----------------------------------------------------------------------------
// radix2_dif_complex_fft
// Unscaled fixed-point radix-2 DIF FFT with one shared butterfly unit.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)                         tlast
// s_axis    in   sample_re[15:0], sample_im[31:16]          -
// m_axis    out  bin_re[22:0], bin_im[45:23], pad to 48     frame_last
//
// A word is taken per cycle while loading. The POINTS-th word starts the
// transform: LOG2_POINTS*POINTS/2 butterflies, each made of two
// sample-memory reads, a capture step, the top write beside the
// multiply and the bottom write; then POINTS bins leave, and no bin read
// is issued while the previous one is pending or the output is stalled.
// s_axis_tready is low from the last load until the read for the last bin
// is issued. Reset clears the sequencer, load count and output flags; the
// sample memory and datapath registers are not cleared.
// ----------------------------------------------------------------------------
module radix2_dif_complex_fft
  import r2fft_pkg::*;
#(
  parameter int unsigned POINTS      = PointsDef,
  parameter int unsigned LOG2_POINTS = Log2PointsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_re, sample_im
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // bin_re, bin_im, zero pad
  output logic        m_axis_tlast    // frame_last
);

  localparam int unsigned AW = (LOG2_POINTS < 1) ? 1 : LOG2_POINTS;
  localparam int unsigned SW = $clog2(LOG2_POINTS + 1);
  localparam int unsigned BW = (LOG2_POINTS > 1) ? LOG2_POINTS - 1 : 1;

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StRdA  = 3'd1;
  localparam logic [2:0] StRdB  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StWrT  = 3'd4;
  localparam logic [2:0] StWrB  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;      // load / output index
  logic [SW-1:0]     stage_q, stage_d;
  logic [BW-1:0]     bfly_q, bfly_d;    // butterfly index in stage
  logic              rd_pend_q;         // output read issued, data not shown

  // sample memory, two 23-bit parts per entry
  logic [2*DataW-1:0] mem_q [POINTS];
  logic [2*DataW-1:0] rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [2*DataW-1:0] mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rdata_q <= mem_q[mem_ra];
  end

  // butterfly datapath registers
  data_t ar_q, ai_q, br_q, bi_q, sr_w, si_w, pr_w, pi_w;
  logic signed [DataW+CoefW-1:0] p0_q, p1_q, p2_q, p3_q;

  // butterfly addresses
  logic [AW-1:0] span, top_a, bot_a, i_low, grp, bit_rev;
  logic [TwIdxW-1:0] tw_m;
  logic [AW-1:0] bfly_ext;

  always_comb begin
    span     = AW'(POINTS >> (stage_q + 1));
    bfly_ext = AW'(bfly_q);
    i_low    = bfly_ext & (span - AW'(1));
    grp      = bfly_ext & ~(span - AW'(1));
    top_a    = (grp << 1) | i_low;
    bot_a    = top_a | span;
    tw_m     = TwIdxW'(({{TwIdxW{1'b0}}, i_low} << stage_q) << (6 - LOG2_POINTS));
    for (int k = 0; k < AW; k++) bit_rev[k] = cnt_q[AW-1-k];
  end

  // rounded Q15 products
  function automatic data_t rnd(input logic signed [DataW+CoefW-1:0] p);
    logic signed [DataW+CoefW-1:0] v;
    v = p + (DataW+CoefW)'(16384);
    return DataW'(v >>> 15);
  endfunction

  logic signed [DataW:0] dr_w, di_w;
  coef_t wr_w, wi_w;
  always_comb begin
    dr_w = {ar_q[DataW-1], ar_q} - {br_q[DataW-1], br_q};
    di_w = {ai_q[DataW-1], ai_q} - {bi_q[DataW-1], bi_q};
    wr_w = cos64(tw_m);
    wi_w = sin64(tw_m);
  end

  logic last_bfly, last_stage, out_fire, out_adv;
  assign last_bfly  = (bfly_q == BW'(POINTS/2 - 1));
  assign last_stage = (stage_q == SW'(LOG2_POINTS - 1));
  assign out_fire   = m_axis_tvalid & m_axis_tready;

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    stage_d = stage_q;
    bfly_d  = bfly_q;
    mem_we  = 1'b0;
    mem_wa  = cnt_q;
    mem_wd  = {{(DataW-SampleW){s_axis_tdata[31]}}, s_axis_tdata[31:16],
               {(DataW-SampleW){s_axis_tdata[15]}}, s_axis_tdata[15:0]};
    mem_ra  = top_a;
    out_adv = 1'b0;
    case (state_q)
      StLoad: begin
        if (s_axis_tvalid) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + AW'(1);
          if (cnt_q == AW'(POINTS - 1)) begin
            state_d = StRdA;
            stage_d = '0;
            bfly_d  = '0;
          end
        end
      end
      StRdA: begin
        mem_ra  = top_a;
        state_d = StRdB;
      end
      StRdB: begin
        mem_ra  = bot_a;
        state_d = StMul;
      end
      StMul: state_d = StWrT;
      StWrT: begin
        mem_we  = 1'b1;
        mem_wa  = top_a;
        mem_wd  = {si_w, sr_w};
        state_d = StWrB;
      end
      StWrB: begin
        mem_we  = 1'b1;
        mem_wa  = bot_a;
        mem_wd  = {pi_w, pr_w};
        state_d = StRdA;
        bfly_d  = bfly_q + BW'(1);
        if (last_bfly) begin
          bfly_d  = '0;
          stage_d = stage_q + SW'(1);
          if (last_stage) begin
            state_d = StOut;
            cnt_d   = '0;
          end
        end
      end
      StOut: begin
        mem_ra = bit_rev;
        // issue a read when no read is pending and the output register is free or draining
        if (!rd_pend_q && (!m_axis_tvalid || m_axis_tready)) begin
          out_adv = 1'b1;
          cnt_d   = cnt_q + AW'(1);
          if (cnt_q == AW'(POINTS - 1)) state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // output stage: an issued read lands in rdata_q, then out_data_q shows it
  logic out_valid_q, out_last_q, pend_last_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      stage_q     <= '0;
      bfly_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      stage_q   <= stage_d;
      bfly_q    <= bfly_d;
      rd_pend_q <= out_adv;
      if (out_adv) pend_last_q <= (cnt_q == AW'(POINTS - 1));
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
        out_last_q  <= pend_last_q;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [2*DataW-1:0] out_data_q;
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) out_data_q <= rdata_q;
    case (state_q)
      StRdB: begin
        ar_q <= data_t'(rdata_q[DataW-1:0]);
        ai_q <= data_t'(rdata_q[2*DataW-1:DataW]);
      end
      StMul: begin
        br_q <= data_t'(rdata_q[DataW-1:0]);
        bi_q <= data_t'(rdata_q[2*DataW-1:DataW]);
      end
      StWrT: begin
        p0_q <= (DataW+CoefW)'(dr_w * wr_w);
        p1_q <= (DataW+CoefW)'(di_w * wi_w);
        p2_q <= (DataW+CoefW)'(dr_w * wi_w);
        p3_q <= (DataW+CoefW)'(di_w * wr_w);
      end
      default: ;
    endcase
  end

  // top sum for the first write, rounded twiddle product for the second
  always_comb begin
    sr_w = ar_q + br_q;
    si_w = ai_q + bi_q;
    pr_w = rnd(p0_q) - rnd(p1_q);
    pi_w = rnd(p2_q) + rnd(p3_q);
  end

  assign s_axis_tready = (state_q == StLoad);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_data_q};

endmodule

FILE: verif/radix2_dif_complex_fft_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix2_dif_complex_fft_test
// Streams frames of complex samples into the FFT and checks every bin against
// a fixed-point DIF transform computed here, with random idling on both sides
// and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module radix2_dif_complex_fft_test;
  import r2fft_pkg::*;

  localparam int unsigned NPts   = PointsDef;
  localparam int unsigned NStg   = Log2PointsDef;
  localparam int unsigned Frames = 4;

  typedef struct packed {
    logic signed [SampleW-1:0] re;
    logic signed [SampleW-1:0] im;
  } sample_t;

  typedef struct packed {
    data_t re;
    data_t im;
    logic  last;
  } bin_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // sample_re, sample_im
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // bin_re, bin_im, zero pad
  logic        m_axis_tlast;   // frame_last

  sample_t pending_samples[$];
  bin_t    expected_bins[$];
  longint  frame_re[NPts];
  longint  frame_im[NPts];
  int      loaded;
  int      mismatches;
  int      cycle_cnt;
  bit      in_taken;
  bit      hold_off;

  radix2_dif_complex_fft u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  // Q1.15 cosine of m/64 turn
  function automatic longint turn_cos(input int m);
    int unsigned qc[17] = '{32767, 32609, 32137, 31356, 30273, 28898, 27245,
                            25329, 23170, 20787, 18204, 15446, 12539, 9512,
                            6393, 3212, 0};
    m = m & 63;
    if (m <= 16) return qc[m];
    if (m <= 32) return -longint'(qc[32-m]);
    if (m <= 48) return -longint'(qc[m-32]);
    return qc[64-m];
  endfunction

  function automatic longint rnd15(input longint p);
    return (p + 16384) >>> 15;
  endfunction

  function automatic longint wrap_data(input longint v);
    data_t d;
    d = v[DataW-1:0];
    return longint'(d);
  endfunction

  // in-place DIF stages, then bins pushed in natural order
  task automatic transform_frame();
    int span, t, b, m, src;
    longint wr, wi, dr, di, sr, si;
    bin_t e;
    for (int stg = 0; stg < NStg; stg++) begin
      span = NPts >> (stg + 1);
      for (int base = 0; base < NPts; base += 2 * span) begin
        for (int i = 0; i < span; i++) begin
          t  = base + i;
          b  = t + span;
          m  = (i << stg) << (6 - NStg);
          wr = turn_cos(m);
          wi = turn_cos(m - 16);
          dr = frame_re[t] - frame_re[b];
          di = frame_im[t] - frame_im[b];
          sr = frame_re[t] + frame_re[b];
          si = frame_im[t] + frame_im[b];
          frame_re[t] = wrap_data(sr);
          frame_im[t] = wrap_data(si);
          frame_re[b] = wrap_data(rnd15(dr * wr) - rnd15(di * wi));
          frame_im[b] = wrap_data(rnd15(dr * wi) + rnd15(di * wr));
        end
      end
    end
    for (int k = 0; k < NPts; k++) begin
      src = 0;
      for (int j = 0; j < NStg; j++) src = (src << 1) | ((k >> j) & 1);
      e.re   = frame_re[src][DataW-1:0];
      e.im   = frame_im[src][DataW-1:0];
      e.last = (k == NPts - 1);
      expected_bins.push_back(e);
    end
  endtask

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // stimulus
  initial begin
    sample_t s;
    int mode;
    // directed extremes in the first frame
    for (int i = 0; i < 24; i++) begin
      case (i % 6)
        0: s = '{16'sh7fff, 16'sh8000};
        1: s = '{16'sh8000, 16'sh7fff};
        2: s = '{16'sh0000, 16'sh0000};
        3: s = '{16'shffff, 16'sh0001};
        4: s = '{16'sh7fff, 16'sh7fff};
        default: s = '{16'sh8000, 16'sh8000};
      endcase
      pending_samples.push_back(s);
    end
    for (int i = 24; i < NPts; i++) begin
      s = sample_t'($urandom);
      pending_samples.push_back(s);
    end
    // full-scale frame for the largest growth
    for (int i = 0; i < NPts; i++) pending_samples.push_back('{16'sh8000, 16'sh8000});
    // random frames, mixed magnitudes
    for (int f = 2; f < Frames; f++) begin
      mode = $urandom_range(2);
      for (int i = 0; i < NPts; i++) begin
        s = sample_t'($urandom);
        if (mode == 1) begin
          s.re = $signed(s.re) >>> $urandom_range(15);
          s.im = $signed(s.im) >>> $urandom_range(15);
        end else if (mode == 2 && $urandom_range(3) == 0) begin
          s.re = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end
        pending_samples.push_back(s);
      end
    end
  end

  // input driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pending_samples.size() > 0 &&
          ((cycle_cnt > 3000 && cycle_cnt < 5000) || $urandom_range(99) >= 14)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_samples.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off &&
        ((cycle_cnt > 3000 && cycle_cnt < 5000) || $urandom_range(99) >= 14);
    end
  end

  // long output hold-off once the first frame is due
  initial begin
    hold_off = 1'b0;
    wait (expected_bins.size() > 0);
    hold_off = 1'b1;
    repeat (1500) @(negedge clk_i);
    hold_off = 1'b0;
  end

  // monitor: predict on input words, check output words
  always @(posedge clk_i or negedge rst_ni) begin
    bin_t e;
    bin_t got;
    if (!rst_ni) begin
      loaded     = 0;
      mismatches = 0;
      cycle_cnt  = 0;
      in_taken   = 1'b0;
    end else begin
      cycle_cnt++;
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        frame_re[loaded] = $signed(s_axis_tdata[15:0]);
        frame_im[loaded] = $signed(s_axis_tdata[31:16]);
        loaded++;
        if (loaded == NPts) begin
          loaded = 0;
          transform_frame();
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[22:0], m_axis_tdata[45:23], m_axis_tlast};
        if (expected_bins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected bin word %h", got);
        end else begin
          e = expected_bins.pop_front();
          if (got != e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("bin mismatch: exp re %0d im %0d last %0b, got re %0d im %0d last %0b",
                       e.re, e.im, e.last, got.re, got.im, got.last);
          end
        end
      end
    end
  end

  // end of run
  initial begin
    wait (rst_ni);
    wait (pending_samples.size() == 0 && !s_axis_tvalid);
    wait (expected_bins.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
